/* rtl/core/mcefm_pkg.sv */
// package for the multi-channel edge frequency meter
// field widths, derived constants and the divider control structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcefm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_BITS   = 16;
    localparam int FRAC_BITS    = 8;

    // fixed field widths
    localparam int CHAN_W  = 2;
    localparam int EDGE_W  = 16;
    localparam int RATE_W  = 27;
    localparam int FREQ_W  = 35;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

    // divider sizing
    localparam int DIVIDEND_W = RATE_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_sts;

endpackage

`default_nettype wire

/* rtl/core/mcefm_if.sv */
// valid/ready channel interfaces for edge items and frequency items
// depends on mcefm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mcefm_in_if;
    logic                        valid;
    logic                        ready;
    logic [mcefm_pkg::CHAN_W-1:0] channel;
    logic [mcefm_pkg::EDGE_W-1:0] edge_count;

    modport source (output valid, output channel, output edge_count, input ready);
    modport sink   (input valid, input channel, input edge_count, output ready);
endinterface

interface mcefm_out_if;
    logic                         valid;
    logic                         ready;
    logic [mcefm_pkg::CHAN_W-1:0] out_channel;
    logic [mcefm_pkg::FREQ_W-1:0] frequency_q8;
    logic                         no_interval;

    modport source (output valid, output out_channel, output frequency_q8,
                    output no_interval, input ready);
    modport sink   (input valid, input out_channel, input frequency_q8,
                    input no_interval, output ready);
endinterface

`default_nettype wire

/* rtl/core/mcefm_divider.sv */
// restoring divider, one quotient bit per clock through one shared subtractor
// depends on mcefm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcefm_divider (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire mcefm_pkg::t_div_req i_req,
    output mcefm_pkg::t_div_sts      o_sts
);

    localparam int DW = mcefm_pkg::DIVIDEND_W;
    localparam int VW = mcefm_pkg::COUNT_BITS;

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [mcefm_pkg::STEP_W-1:0]    r_step, n_step;
    logic [VW-1:0]                   r_rem, n_rem;
    logic [VW-1:0]                   r_divisor, n_divisor;
    logic [DW-1:0]                   r_quo, n_quo;

    logic [VW:0]   w_trial;
    logic [VW+1:0] w_diff;
    logic          w_fits;

    // shift the next dividend bit into the partial remainder and try a subtract
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_divisor};
    assign w_fits  = ~w_diff[VW+1];

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_step    = r_step;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_quo     = r_quo;
        if (i_req.start && !r_busy) begin
            n_busy    = 1'b1;
            n_step    = mcefm_pkg::STEP_W'(DW - 1);
            n_rem     = '0;
            n_divisor = i_req.divisor;
            n_quo     = i_req.dividend;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[VW-1:0] : w_trial[VW-1:0];
            n_quo = {r_quo[DW-2:0], w_fits};
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step    <= n_step;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_quo     <= n_quo;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

    // done is a single pulse after the last step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding busy cycle");

endmodule

`default_nettype wire

/* rtl/core/multi_channel_edge_frequency_meter_top.sv */
// top level of the multi-channel edge frequency meter: channel store, sequencer, output register
// depends on mcefm_pkg, mcefm_if and mcefm_divider
`timescale 1ns / 1ps
`default_nettype none

// Each accepted edge item carries a channel and the capture-counter value at that edge.
// The block forms the interval to the previous edge of that channel modulo 2^16 (so one
// counter wrap is absorbed), stores the new count and returns one item with
// floor((tick_rate_hz << 8) / interval) as an unsigned Q27.8 frequency in Hz. A zero
// interval returns frequency 0 with no_interval set. Previous counts reset to zero, so
// the first edge of a channel is measured against zero. One item is worked on at a time:
// an edge with a non-zero interval passes a load step, the restoring divider (35 quotient
// bits at one bit per clock), a step to pick up the quotient and a hand-off to the output
// register once it is free before the next edge can be taken, and a zero interval goes
// straight to the hand-off. The output register lets the next edge be accepted while a
// result still waits to be taken. tick_rate_hz is written through i_cfg_wr_en and
// resets to 1000000; write it only while the block is idle.

module multi_channel_edge_frequency_meter_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire [mcefm_pkg::RATE_W-1:0]        i_cfg_wr_data,
    mcefm_in_if.sink                           i_in,
    mcefm_out_if.source                        o_out
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    localparam int CW = mcefm_pkg::COUNT_BITS;

    logic [1:0]                      r_state, n_state;
    logic [mcefm_pkg::RATE_W-1:0]    r_rate;
    logic [CW-1:0]                   r_prev [mcefm_pkg::NUM_CHANNELS];
    logic [mcefm_pkg::CHAN_W-1:0]    r_chan;
    logic                            r_none;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [mcefm_pkg::CHAN_W-1:0]    r_out_chan;
    logic [mcefm_pkg::FREQ_W-1:0]    r_out_freq;
    logic                            r_out_none;

    logic          w_in_fire;
    logic          w_chan_ok;
    logic [CW-1:0] w_now;
    logic [CW-1:0] w_interval;
    logic          w_out_free;
    logic          w_load_out;

    mcefm_pkg::t_div_req w_div_req;
    mcefm_pkg::t_div_sts w_div_sts;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;

    // edges on channels beyond the channel count are taken and dropped
    assign w_chan_ok  = (32'(i_in.channel) < mcefm_pkg::NUM_CHANNELS);
    assign w_now      = i_in.edge_count[CW-1:0];
    // modular difference absorbs a single counter wrap
    assign w_interval = w_now - r_prev[i_in.channel];

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load_out = (r_state == S_HOLD) && w_out_free;

    // divider launch, dividend is the tick rate scaled by the fraction bits
    assign w_div_req.start    = w_in_fire && w_chan_ok && (w_interval != '0);
    assign w_div_req.dividend = {r_rate, {mcefm_pkg::FRAC_BITS{1'b0}}};
    assign w_div_req.divisor  = w_interval;

    mcefm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_sts   (w_div_sts)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && w_chan_ok) begin
                    n_state = (w_interval == '0) ? S_HOLD : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rate      <= mcefm_pkg::RATE_RESET;
            for (int i = 0; i < mcefm_pkg::NUM_CHANNELS; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            if (w_in_fire && w_chan_ok) begin
                r_prev[i_in.channel] <= w_now;
            end
        end
        // item context held while the divider runs
        if (w_in_fire) begin
            r_chan <= i_in.channel;
            r_none <= (w_interval == '0);
        end
        if (w_load_out) begin
            r_out_chan <= r_chan;
            r_out_none <= r_none;
            r_out_freq <= r_none ? '0 : mcefm_pkg::FREQ_W'(w_div_sts.quotient);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_channel  = r_out_chan;
    assign o_out.frequency_q8 = r_out_freq;
    assign o_out.no_interval  = r_out_none;

    // a zero interval never carries a frequency
    a_none_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.no_interval |-> o_out.frequency_q8 == '0)
        else $error("no_interval item with non-zero frequency");

    // the divider is only launched from idle and only finishes while awaited
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> r_state == S_IDLE && !w_div_sts.busy)
        else $error("divider launched while not idle");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    // a valid edge always leaves idle on the next cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && w_chan_ok |=> r_state != S_IDLE)
        else $error("accepted edge did not start work");

endmodule

`default_nettype wire
